// ===== hw/rtl/uart8n1_pkg.sv =====
// Shared types and constants for the 8N1 UART transceiver.
package uart8n1_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_BIT_TICKS      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HALF_BIT_TICKS = 2'd1;

  // Configuration data width and reset values.
  localparam int unsigned CfgDataW        = 16;
  localparam logic [15:0] BIT_TICKS_RST   = 16'd104;
  localparam logic [14:0] HALF_TICKS_RST  = 15'd52;

  // Frame layout.
  localparam logic [3:0] TX_FRAME_BITS = 4'd10;
  localparam logic [3:0] RX_DATA_BITS  = 4'd8;

  // One input request: a tick of the bit-timing counter.
  typedef struct packed {
    logic       rxd;
    logic       tx_load;
    logic [7:0] tx_byte;
  } in_t;

  // One result: line and status levels after the tick.
  typedef struct packed {
    logic       txd;
    logic       tx_busy;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } out_t;

  // Live configuration register values.
  typedef struct packed {
    logic [15:0] bit_ticks;
    logic [14:0] half_bit_ticks;
  } cfg_t;

endpackage

// ===== hw/rtl/uart8n1_tx.sv =====
// Transmitter: frames a byte as start, eight data bits LSB first and stop.
module uart8n1_tx #(
  parameter int unsigned TICK_COUNTER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              tx_load,
  input  logic [7:0]        tx_byte,
  input  uart8n1_pkg::cfg_t cfg,
  output logic              txd,
  output logic              tx_busy
);

  localparam int unsigned CntW = TICK_COUNTER_BITS;
  localparam int unsigned CmpW = (CntW > 17) ? CntW : 17;

  logic [9:0]      shift_r, shift_nxt;
  logic [3:0]      bits_r, bits_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            active_r, active_nxt;
  logic            line_r, line_nxt;

  logic [CntW-1:0] cnt_inc;
  logic [CmpW-1:0] inc_ext, lim_ext;
  logic            period_end;

  // Bit period timing: over when the count reaches the limit or saturates.
  always_comb begin
    cnt_inc    = cnt_r + CntW'(1);
    inc_ext    = CmpW'(cnt_inc);
    lim_ext    = CmpW'(cfg.bit_ticks);
    period_end = (inc_ext >= lim_ext) || (&cnt_inc);
  end

  // Next state for one tick.
  always_comb begin
    shift_nxt  = shift_r;
    bits_nxt   = bits_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    line_nxt   = line_r;
    if (step) begin
      if (!active_r) begin
        if (tx_load) begin
          shift_nxt  = {1'b1, tx_byte, 1'b0};
          bits_nxt   = uart8n1_pkg::TX_FRAME_BITS;
          cnt_nxt    = '0;
          active_nxt = 1'b1;
          line_nxt   = 1'b1;
        end
      end else if (period_end) begin
        cnt_nxt = '0;
        if (bits_r == 4'd0) begin
          active_nxt = 1'b0;
          line_nxt   = 1'b1;
        end else begin
          line_nxt  = shift_r[0];
          shift_nxt = {1'b1, shift_r[9:1]};
          bits_nxt  = bits_r - 4'd1;
        end
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= '1;
      bits_r   <= '0;
      cnt_r    <= '0;
      active_r <= 1'b0;
      line_r   <= 1'b1;
    end else begin
      shift_r  <= shift_nxt;
      bits_r   <= bits_nxt;
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
      line_r   <= line_nxt;
    end
  end

  // Results are the levels after this tick.
  assign txd     = line_nxt;
  assign tx_busy = active_nxt;

endmodule

// ===== hw/rtl/uart8n1_rx.sv =====
// Receiver: finds a start edge and samples eight bits at bit centers.
module uart8n1_rx #(
  parameter int unsigned TICK_COUNTER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              rxd,
  input  uart8n1_pkg::cfg_t cfg,
  output logic              rx_valid,
  output logic [7:0]        rx_byte
);

  localparam int unsigned CntW = TICK_COUNTER_BITS;
  localparam int unsigned CmpW = (CntW > 17) ? CntW : 17;

  logic [7:0]      shift_r, shift_nxt;
  logic [3:0]      bits_r, bits_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            hunt_r, hunt_nxt;
  logic            prev_r, prev_nxt;
  logic [7:0]      hold_r, hold_nxt;
  logic            valid;

  logic [CntW-1:0] cnt_inc;
  logic [16:0]     limit;
  logic [CmpW-1:0] inc_ext, lim_ext;
  logic            period_end;
  logic [3:0]      bits_dec;

  // Sample timing: the first sample waits an extra half bit period.
  always_comb begin
    cnt_inc = cnt_r + CntW'(1);
    limit   = {1'b0, cfg.bit_ticks} +
              ((bits_r >= uart8n1_pkg::RX_DATA_BITS) ? {2'b00, cfg.half_bit_ticks} : 17'd0);
    inc_ext    = CmpW'(cnt_inc);
    lim_ext    = CmpW'(limit);
    period_end = (inc_ext >= lim_ext) || (&cnt_inc);
    bits_dec   = bits_r - 4'd1;
  end

  // Next state for one tick.
  always_comb begin
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    cnt_nxt   = cnt_r;
    hunt_nxt  = hunt_r;
    prev_nxt  = prev_r;
    hold_nxt  = hold_r;
    valid     = 1'b0;
    if (step) begin
      prev_nxt = rxd;
      if (hunt_r) begin
        if (prev_r && !rxd) begin
          hunt_nxt = 1'b0;
          cnt_nxt  = '0;
          bits_nxt = uart8n1_pkg::RX_DATA_BITS;
        end
      end else if (period_end) begin
        cnt_nxt   = '0;
        shift_nxt = {rxd, shift_r[7:1]};
        bits_nxt  = bits_dec;
        if ((bits_dec == 4'd0) || (bits_dec > uart8n1_pkg::RX_DATA_BITS)) begin
          hold_nxt = {rxd, shift_r[7:1]};
          valid    = 1'b1;
          bits_nxt = uart8n1_pkg::RX_DATA_BITS;
          hunt_nxt = 1'b1;
        end
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      bits_r  <= uart8n1_pkg::RX_DATA_BITS;
      cnt_r   <= '0;
      hunt_r  <= 1'b1;
      prev_r  <= 1'b1;
      hold_r  <= '0;
    end else begin
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
      cnt_r   <= cnt_nxt;
      hunt_r  <= hunt_nxt;
      prev_r  <= prev_nxt;
      hold_r  <= hold_nxt;
    end
  end

  assign rx_valid = valid;
  assign rx_byte  = hold_nxt;

endmodule

// ===== hw/rtl/uart8n1_obuf.sv =====
// Two-entry result buffer: output register plus skid register.
module uart8n1_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  uart8n1_pkg::out_t push_data,
  output logic              out_valid,
  input  logic              out_ready,
  output uart8n1_pkg::out_t out_data
);

  logic              main_valid_r;
  logic              skid_valid_r;
  uart8n1_pkg::out_t main_r;
  uart8n1_pkg::out_t skid_r;
  logic              pop;
  logic              push;

  assign push_ready = !skid_valid_r;
  assign pop        = main_valid_r && out_ready;
  assign push       = push_valid && push_ready;

  // Control: valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!main_valid_r || pop) begin
      main_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (!main_valid_r || pop) begin
      if (push) begin
        main_r <= push_data;
      end
    end else if (push) begin
      skid_r <= push_data;
    end
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

// ===== hw/rtl/uart_8n1_transceiver.sv =====
// Top level of the tick-driven 8N1 UART transceiver.
//
// Each input request is one tick of the bit-timing counter and carries the
// receive line level, a transmit load flag and the byte to send. Each
// accepted request yields exactly one result: the transmit line level, the
// busy flag, a one-tick receive valid and the last received byte, all as
// they stand after that tick.
// Throughput: one request per cycle while in_ready is high; the
// transmitter and receiver state advance in a single pass of short logic
// per tick. A two-entry result buffer registers each result in its output
// register, or in its skid register while an untaken result waits, so the
// block can take a request while one result still waits; in_ready drops
// only when both entries are full, and rises again once the receiver takes
// one. A stalled receiver therefore stalls the tick stream, with no loss.
// Reset (rst_n low, synchronous) empties the buffer, idles the line high,
// sets the receiver hunting for a start edge and loads bit_ticks = 104 and
// half_bit_ticks = 52. Configuration writes on cfg_we take effect at the
// next tick; unknown indexes are ignored.
module uart_8n1_transceiver #(
  parameter int unsigned TICK_COUNTER_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  uart8n1_pkg::in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output uart8n1_pkg::out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [uart8n1_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [uart8n1_pkg::CfgDataW-1:0]    cfg_wdata
);

  uart8n1_pkg::cfg_t cfg_r;
  uart8n1_pkg::out_t result;
  logic              step;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_ticks      <= uart8n1_pkg::BIT_TICKS_RST;
      cfg_r.half_bit_ticks <= uart8n1_pkg::HALF_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        uart8n1_pkg::CFG_BIT_TICKS:      cfg_r.bit_ticks      <= cfg_wdata;
        uart8n1_pkg::CFG_HALF_BIT_TICKS: cfg_r.half_bit_ticks <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // A tick advances the state when its request is accepted.
  assign step = in_valid && in_ready;

  // Transmitter.
  uart8n1_tx #(
    .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
  ) u_tx (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .tx_load (in_data.tx_load),
    .tx_byte (in_data.tx_byte),
    .cfg     (cfg_r),
    .txd     (result.txd),
    .tx_busy (result.tx_busy)
  );

  // Receiver.
  uart8n1_rx #(
    .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
  ) u_rx (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rxd      (in_data.rxd),
    .cfg      (cfg_r),
    .rx_valid (result.rx_valid),
    .rx_byte  (result.rx_byte)
  );

  // Result buffer.
  uart8n1_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== hw/rtl/uart8n1_chk.sv =====
// Port-level checker for the UART transceiver and its bind statement.
module uart8n1_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input uart8n1_pkg::out_t out_data
);

  // Back-pressure only appears when a result is already waiting.
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result waiting");

  // Every accepted request leaves a result waiting on the next cycle.
  a_accept_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted request left no result waiting");

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed or vanished while stalled");

  // An idle transmitter holds the line high.
  a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.tx_busy) |-> out_data.txd)
    else $error("txd low while transmitter idle");

  // Reset empties the result buffer.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("result buffer not empty after reset");

endmodule

bind uart_8n1_transceiver uart8n1_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
